### design/lfid_pkg.sv
// Shared constants, codes and types of the lowest-free identifier allocator.
`timescale 1ns / 1ps
`default_nettype none

package lfid_pkg;

    // Default pool and requester counts.
    localparam int LFID_NUM_IDS = 64;
    localparam int LFID_NUM_REQ = 64;

    // Fixed field widths of the stream beats.
    localparam int LFID_REQ_W    = 6;
    localparam int LFID_HID_W    = 6;
    localparam int LFID_CNT_W    = 7;
    localparam int LFID_IN_DW    = 8;
    localparam int LFID_OUT_DW   = 24;

    // Operation carried in the input tuser.
    typedef enum logic {
        FN_ALLOC   = 1'b0,
        FN_RELEASE = 1'b1
    } t_func;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_HELD      = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_RELEASED  = 2'd3
    } t_status;

    // Flags reported by the map scanner.
    typedef struct packed {
        logic free_found;
        logic any_used;
    } t_scan_flags;

endpackage

`default_nettype wire

### design/lowest_free_id_allocator_core.sv
// Top level of the lowest-free identifier allocator with stream ports.
// An accepted input beat passes the input register, then one pass of the map encoders
// and table update into the output register as its result beat. Throughput: one request
// per cycle unless the output stalls; the map, holder flags and count update per request.
// Reset (i_rst_n low, synchronous): every identifier free, no requester holds one,
// count zero, both stages empty. The holder identifier table is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module lowest_free_id_allocator_core #(
    parameter int NUM_IDS        = lfid_pkg::LFID_NUM_IDS,
    parameter int NUM_REQUESTERS = lfid_pkg::LFID_NUM_REQ
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // [5:0] requester, [7:6] zero
    input  wire logic [lfid_pkg::LFID_IN_DW-1:0]  s_axis_tdata,
    // [0] func
    input  wire logic                         s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // [1:0] status, [2] held_valid, [8:3] held_id, [15:9] in_use_count,
    // [16] max_valid, [22:17] max_in_use, [23] zero
    output logic [lfid_pkg::LFID_OUT_DW-1:0] m_axis_tdata
);
    import lfid_pkg::*;

    localparam int ID_W   = $clog2(NUM_IDS);
    localparam int CNT_W  = $clog2(NUM_IDS + 1);
    localparam int REQ_AW = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;
    localparam int REQ_XW = (REQ_AW > LFID_REQ_W) ? REQ_AW : LFID_REQ_W;

    // Input stage
    logic                  r_in_valid;
    t_func                 r_func;
    logic [LFID_REQ_W-1:0] r_req;
    logic [ID_W-1:0]       r_hid_rd;

    // Allocator state
    logic [NUM_IDS-1:0]        r_used_map;
    logic [NUM_REQUESTERS-1:0] r_holder_valid;
    logic [ID_W-1:0]           r_holder_id [NUM_REQUESTERS];
    logic [CNT_W-1:0]          r_count;

    // Output stage
    logic                   r_out_valid;
    logic [LFID_OUT_DW-1:0] r_out_data;

    // Processing signals
    logic                  w_fire;
    logic                  w_accept;
    logic [REQ_XW-1:0]     w_req_x;
    logic [REQ_AW-1:0]     w_idx;
    logic [REQ_XW-1:0]     w_in_req_x;
    logic [REQ_AW-1:0]     w_in_idx;
    logic                  w_req_ok;
    logic                  w_hv_old;
    logic                  w_alloc;
    logic                  w_alloc_ok;
    logic                  w_rel_do;
    logic [NUM_IDS-1:0]    w_rel_mask;
    logic [NUM_IDS-1:0]    w_set_mask;
    logic [NUM_IDS-1:0]    w_keep_map;
    t_scan_flags           w_scan;
    logic [ID_W-1:0]       w_free_id;
    logic [ID_W-1:0]       w_scan_max;
    t_status               w_status;
    logic                  w_hv_new;
    logic [ID_W-1:0]       w_hid_new;
    logic                  w_max_valid;
    logic [ID_W-1:0]       w_max_id;
    logic [NUM_IDS-1:0]    n_used_map;
    logic [CNT_W-1:0]      n_count;
    logic [LFID_OUT_DW-1:0] n_out_data;

    // Handshake: the stage processes when the output register is free or draining.
    assign w_fire        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_fire;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Requester indexes for the stage and for the incoming beat.
    assign w_req_x    = REQ_XW'(r_req);
    assign w_idx      = w_req_x[REQ_AW-1:0];
    assign w_in_req_x = REQ_XW'(s_axis_tdata[LFID_REQ_W-1:0]);
    assign w_in_idx   = w_in_req_x[REQ_AW-1:0];

    // Request decode against the current state.
    assign w_req_ok   = 32'(r_req) < NUM_REQUESTERS;
    assign w_hv_old   = w_req_ok && r_holder_valid[w_idx];
    assign w_alloc    = w_req_ok && (r_func == FN_ALLOC);
    assign w_alloc_ok = w_alloc && !w_hv_old && w_scan.free_found;
    assign w_rel_do   = w_req_ok && (r_func == FN_RELEASE) && w_hv_old;

    assign w_rel_mask = w_rel_do ? ({{(NUM_IDS-1){1'b0}}, 1'b1} << r_hid_rd) : '0;
    assign w_set_mask = w_alloc_ok ? ({{(NUM_IDS-1){1'b0}}, 1'b1} << w_free_id) : '0;
    assign w_keep_map = r_used_map & ~w_rel_mask;

    lfid_scan #(
        .NUM_IDS (NUM_IDS),
        .ID_W    (ID_W)
    ) u_scan (
        .i_used_map (r_used_map),
        .i_keep_map (w_keep_map),
        .o_flags    (w_scan),
        .o_free_id  (w_free_id),
        .o_max_id   (w_scan_max)
    );

    // Next state of the map and the count.
    assign n_used_map = w_keep_map | w_set_mask;
    assign n_count    = r_count + CNT_W'(w_alloc_ok) - CNT_W'(w_rel_do);

    // Status of the request.
    always_comb begin
        priority if (!w_req_ok || !w_alloc) begin
            w_status = ST_RELEASED;
        end else if (w_hv_old) begin
            w_status = ST_HELD;
        end else if (w_scan.free_found) begin
            w_status = ST_ALLOCATED;
        end else begin
            w_status = ST_EXHAUSTED;
        end
    end

    // Held identifier after the step; a release always leaves nothing held.
    assign w_hv_new  = w_alloc && (w_hv_old || w_scan.free_found);
    assign w_hid_new = w_alloc_ok ? w_free_id : ((w_alloc && w_hv_old) ? r_hid_rd : '0);

    // Highest in use: the kept map's maximum, raised by a fresh allocation.
    assign w_max_valid = w_scan.any_used || w_alloc_ok;
    assign w_max_id    = (w_alloc_ok && (!w_scan.any_used || (w_free_id > w_scan_max))) ?
                         w_free_id : w_scan_max;

    assign n_out_data = {1'b0,
                         LFID_HID_W'(w_max_id),
                         w_max_valid,
                         LFID_CNT_W'(n_count),
                         LFID_HID_W'(w_hid_new),
                         w_hv_new,
                         w_status};

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
        if (w_accept) begin
            r_func <= t_func'(s_axis_tuser);
            r_req  <= s_axis_tdata[LFID_REQ_W-1:0];
        end
    end

    // Holder identifier table; a write in the same cycle is forwarded to the read.
    always_ff @(posedge i_clk) begin
        if (w_fire && w_alloc_ok) begin
            r_holder_id[w_idx] <= w_free_id;
        end
        if (w_accept) begin
            if (w_fire && w_alloc_ok && (w_idx == w_in_idx)) begin
                r_hid_rd <= w_free_id;
            end else begin
                r_hid_rd <= r_holder_id[w_in_idx];
            end
        end
    end

    // Map, holder flags and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_map     <= '0;
            r_holder_valid <= '0;
            r_count        <= '0;
        end else if (w_fire) begin
            r_used_map <= n_used_map;
            r_count    <= n_count;
            if (w_alloc_ok) begin
                r_holder_valid[w_idx] <= 1'b1;
            end else if (w_rel_do) begin
                r_holder_valid[w_idx] <= 1'b0;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_fire) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // The count always equals the number of identifiers marked in use.
    a_count_map : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_used_map) == r_count)
        else $error("count disagrees with the used map");

    // The number of requesters holding an identifier equals the count in use.
    a_count_holders : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_holder_valid) == r_count)
        else $error("holder flags disagree with the count");

    // A granted identifier was free before the grant.
    a_grant_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_alloc_ok) |-> !r_used_map[w_free_id])
        else $error("granted an identifier already in use");

    // A release leaves the requester without an identifier.
    a_release_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_rel_do) |=> !r_holder_valid[$past(w_idx)])
        else $error("release did not clear the holder flag");

endmodule

`default_nettype wire

### design/lfid_scan.sv
// Priority encoders over the identifier map: lowest free and highest kept in use.
`timescale 1ns / 1ps
`default_nettype none

module lfid_scan #(
    parameter int NUM_IDS = lfid_pkg::LFID_NUM_IDS,
    parameter int ID_W    = $clog2(NUM_IDS)
) (
    input  wire logic [NUM_IDS-1:0] i_used_map,
    input  wire logic [NUM_IDS-1:0] i_keep_map,
    output lfid_pkg::t_scan_flags   o_flags,
    output logic [ID_W-1:0]         o_free_id,
    output logic [ID_W-1:0]         o_max_id
);
    import lfid_pkg::*;

    // Lowest clear bit of the used map; the last match from the top wins.
    always_comb begin
        o_free_id = '0;
        for (int i = NUM_IDS - 1; i >= 0; i--) begin
            if (!i_used_map[i]) begin
                o_free_id = ID_W'(i);
            end
        end
    end

    // Highest set bit of the kept map; zero when the map is empty.
    always_comb begin
        o_max_id = '0;
        for (int i = 0; i < NUM_IDS; i++) begin
            if (i_keep_map[i]) begin
                o_max_id = ID_W'(i);
            end
        end
    end

    assign o_flags.free_found = ~&i_used_map;
    assign o_flags.any_used   = |i_keep_map;

endmodule

`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for the lowest-free identifier allocator core.
`timescale 1ns / 1ps

module tb_top;
    import lfid_pkg::*;

    localparam int NIDS           = LFID_NUM_IDS;
    localparam int NREQ           = LFID_NUM_REQ;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int QUIET_TAIL     = 150;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int MAX_REPORTS    = 10;

    // One reply beat, split into its fields.
    typedef struct packed {
        t_status    status;
        logic       held_vld;
        logic [5:0] held_id;
        logic [6:0] count;
        logic       max_vld;
        logic [5:0] max_id;
    } t_reply;

    // A row of the directed table; the reply is only used where typed is set.
    typedef struct packed {
        t_func      func;
        logic [5:0] req;
        logic       typed;
        t_reply     reply;
    } t_row;

    // What the request side tells the checker about each beat it offers.
    typedef struct packed {
        logic   typed;
        t_reply reply;
    } t_hint;

    typedef int t_order [NREQ];

    // Directed table: reset state, both requester extremes, alternating bit patterns,
    // allocate while holding, release while holding nothing and lowest-free reuse.
    localparam t_row DIR_ROWS [21] = '{
        '{FN_RELEASE, 6'd0,  1'b1, '{ST_RELEASED,  1'b0, 6'd0, 7'd0, 1'b0, 6'd0}},
        '{FN_ALLOC,   6'd0,  1'b1, '{ST_ALLOCATED, 1'b1, 6'd0, 7'd1, 1'b1, 6'd0}},
        '{FN_ALLOC,   6'd63, 1'b1, '{ST_ALLOCATED, 1'b1, 6'd1, 7'd2, 1'b1, 6'd1}},
        '{FN_ALLOC,   6'd0,  1'b1, '{ST_HELD,      1'b1, 6'd0, 7'd2, 1'b1, 6'd1}},
        '{FN_ALLOC,   6'd63, 1'b1, '{ST_HELD,      1'b1, 6'd1, 7'd2, 1'b1, 6'd1}},
        '{FN_RELEASE, 6'd63, 1'b1, '{ST_RELEASED,  1'b0, 6'd0, 7'd1, 1'b1, 6'd0}},
        '{FN_RELEASE, 6'd63, 1'b1, '{ST_RELEASED,  1'b0, 6'd0, 7'd1, 1'b1, 6'd0}},
        '{FN_ALLOC,   6'd42, 1'b1, '{ST_ALLOCATED, 1'b1, 6'd1, 7'd2, 1'b1, 6'd1}},
        '{FN_RELEASE, 6'd0,  1'b1, '{ST_RELEASED,  1'b0, 6'd0, 7'd1, 1'b1, 6'd1}},
        '{FN_ALLOC,   6'd21, 1'b1, '{ST_ALLOCATED, 1'b1, 6'd0, 7'd2, 1'b1, 6'd1}},
        '{FN_ALLOC,   6'd0,  1'b0, '0},
        '{FN_ALLOC,   6'd63, 1'b0, '0},
        '{FN_RELEASE, 6'd42, 1'b0, '0},
        '{FN_ALLOC,   6'd1,  1'b0, '0},
        '{FN_RELEASE, 6'd21, 1'b0, '0},
        '{FN_RELEASE, 6'd0,  1'b0, '0},
        '{FN_RELEASE, 6'd63, 1'b0, '0},
        '{FN_RELEASE, 6'd1,  1'b0, '0},
        '{FN_RELEASE, 6'd1,  1'b1, '{ST_RELEASED,  1'b0, 6'd0, 7'd0, 1'b0, 6'd0}},
        '{FN_ALLOC,   6'd32, 1'b1, '{ST_ALLOCATED, 1'b1, 6'd0, 7'd1, 1'b1, 6'd0}},
        '{FN_RELEASE, 6'd32, 1'b1, '{ST_RELEASED,  1'b0, 6'd0, 7'd0, 1'b0, 6'd0}}
    };

    // Block ports; the inputs are driven to known values from time zero.
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [5:0] requester, [7:6] zero
    logic [LFID_IN_DW-1:0]  s_axis_tdata  = '0;
    // [0] func
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [1:0] status, [2] held_valid, [8:3] held_id, [15:9] in_use_count,
    // [16] max_valid, [22:17] max_in_use, [23] zero
    logic [LFID_OUT_DW-1:0] m_axis_tdata;

    // Mirror of the allocator state.
    logic [NIDS-1:0] id_busy;
    logic [NREQ-1:0] req_holds;
    logic [5:0]      req_id [NREQ];
    int              busy_total;

    t_reply expected_replies [$];
    t_hint  table_hints [$];

    logic gaps_on     = 1'b1;
    int   hold_ticket = 0;
    int   reqs_sent   = 0;
    int   replies_checked = 0;
    int   mismatches  = 0;
    int   peak_busy   = 0;
    int   status_seen [4] = '{0, 0, 0, 0};

    lowest_free_id_allocator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Free-running clock.
    initial begin
        forever begin
            #6 i_clk = ~i_clk;
        end
    end

    // Hard limit on the run time.
    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    // Applies one request to the mirrored state and returns the reply it should give.
    function automatic t_reply apply_request(t_func f, logic [5:0] r);
        t_reply rep;
        int     slot;
        rep        = '0;
        rep.status = ST_RELEASED;
        if (int'(r) < NREQ) begin
            if (f == FN_ALLOC) begin
                if (req_holds[r]) begin
                    rep.status = ST_HELD;
                end else begin
                    slot = -1;
                    for (int i = NIDS - 1; i >= 0; i--) begin
                        if (!id_busy[i]) slot = i;
                    end
                    if (slot < 0) begin
                        rep.status = ST_EXHAUSTED;
                    end else begin
                        id_busy[slot] = 1'b1;
                        req_holds[r]  = 1'b1;
                        req_id[r]     = 6'(slot);
                        busy_total++;
                        rep.status    = ST_ALLOCATED;
                    end
                end
            end else if (req_holds[r]) begin
                if (id_busy[req_id[r]]) begin
                    id_busy[req_id[r]] = 1'b0;
                    if (busy_total > 0) busy_total--;
                end
                req_holds[r] = 1'b0;
                req_id[r]    = '0;
            end
            rep.held_vld = req_holds[r];
            rep.held_id  = req_holds[r] ? req_id[r] : 6'd0;
        end
        rep.count = 7'(busy_total);
        for (int i = 0; i < NIDS; i++) begin
            if (id_busy[i]) begin
                rep.max_vld = 1'b1;
                rep.max_id  = 6'(i);
            end
        end
        return rep;
    endfunction

    function automatic string reply_text(t_reply rep);
        return $sformatf("status=%0d held=%0b/%0d count=%0d max=%0b/%0d", rep.status,
                         rep.held_vld, rep.held_id, rep.count, rep.max_vld, rep.max_id);
    endfunction

    function automatic void note_fault(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function automatic t_order shuffled_requesters();
        t_order order;
        int     j;
        int     tmp;
        foreach (order[k]) order[k] = k;
        for (int k = NREQ - 1; k > 0; k--) begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        return order;
    endfunction

    // Prediction on each accepted request beat, then checking of each reply beat.
    always @(posedge i_clk) begin
        t_hint  hint;
        t_reply want;
        t_reply got;
        if (!i_rst_n) begin
            id_busy    = '0;
            req_holds  = '0;
            busy_total = 0;
            foreach (req_id[k]) req_id[k] = '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                hint = table_hints.pop_front();
                want = apply_request(t_func'(s_axis_tuser), s_axis_tdata[LFID_REQ_W-1:0]);
                if (hint.typed) want = hint.reply;
                expected_replies.push_back(want);
                if (busy_total > peak_busy) peak_busy = busy_total;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.status   = t_status'(m_axis_tdata[1:0]);
                got.held_vld = m_axis_tdata[2];
                got.held_id  = m_axis_tdata[8:3];
                got.count    = m_axis_tdata[15:9];
                got.max_vld  = m_axis_tdata[16];
                got.max_id   = m_axis_tdata[22:17];
                status_seen[int'(got.status)]++;
                if (expected_replies.size() == 0) begin
                    note_fault($sformatf("%0t: unexpected reply %s", $realtime,
                                         reply_text(got)));
                end else begin
                    want = expected_replies.pop_front();
                    replies_checked++;
                    if (got.status !== want.status || got.held_vld !== want.held_vld ||
                        got.held_id !== want.held_id || got.count !== want.count ||
                        got.max_vld !== want.max_vld || got.max_id !== want.max_id) begin
                        note_fault($sformatf("%0t: reply %0d expected %s, got %s", $realtime,
                                             replies_checked, reply_text(want),
                                             reply_text(got)));
                    end
                end
            end
        end
    end

    // Reply side: random stall bursts, plus one long hold-off on request.
    initial begin
        int served;
        served = 0;
        forever begin
            @(posedge i_clk);
            if (hold_ticket != served) begin
                served = hold_ticket;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Offers one request beat and returns at the edge where it is taken.
    task automatic send_req(input t_func f, input logic [5:0] r,
                            input logic typed = 1'b0, input t_reply rep = '0);
        t_hint hint;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        hint.typed = typed;
        hint.reply = rep;
        table_hints.push_back(hint);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, r};
        s_axis_tuser  <= f;
        do @(posedge i_clk); while (!s_axis_tready);
        reqs_sent++;
    endtask

    // Stops offering beats until every expected reply has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_replies.size() != 0);
    endtask

    task automatic send_random(input int n, input int top_req);
        repeat (n) begin
            send_req(t_func'($urandom_range(0, 1)), 6'($urandom_range(0, top_req)));
        end
    endtask

    // Every requester allocates in random order until the pool is full, eight random
    // requests follow, then a random share of at least half of the requesters release.
    task automatic fill_and_empty();
        t_order order;
        int     last;
        order = shuffled_requesters();
        foreach (order[k]) send_req(FN_ALLOC, 6'(order[k]));
        send_random(8, NREQ - 1);
        order = shuffled_requesters();
        last  = $urandom_range(NREQ / 2, NREQ);
        for (int k = 0; k < last; k++) send_req(FN_RELEASE, 6'(order[k]));
    endtask

    // Request side and end of run.
    initial begin
        logic hold_done;
        hold_done = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIR_ROWS[k]) begin
            send_req(DIR_ROWS[k].func, DIR_ROWS[k].req, DIR_ROWS[k].typed, DIR_ROWS[k].reply);
        end
        wait_drained();
        fill_and_empty();

        while (reqs_sent < RANDOM_ITEMS) begin
            // Long reply hold-off while requests keep coming, then a full drain.
            if (!hold_done && reqs_sent >= RANDOM_ITEMS * 2 / 5) begin
                hold_done = 1'b1;
                hold_ticket <= hold_ticket + 1;
                gaps_on     <= 1'b0;
                send_random(24, NREQ - 1);
                wait_drained();
            end
            if (reqs_sent >= RANDOM_ITEMS - QUIET_TAIL) begin
                gaps_on <= 1'b0;
            end else begin
                gaps_on <= ($urandom_range(0, 3) != 0);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    send_random(20, NREQ - 1);
                end
                6, 7: begin
                    // A few requesters churning through hold and release.
                    send_random(20, 7);
                end
                default: begin
                    fill_and_empty();
                end
            endcase
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("Ran %0d requests, checked %0d replies, peak occupancy %0d of %0d.",
                 reqs_sent, replies_checked, peak_busy, NIDS);
        $display("Replies by status: allocated %0d, held %0d, exhausted %0d, released %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
